[rtl/efr_pkg.sv]
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants for the escaped frame receiver
// Holds register codes, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package efr_pkg;

  localparam int unsigned FRAME_CAPACITY = 128;

  localparam logic [7:0] NO_FRAME = 8'hFF;

  // register reset values
  localparam logic [7:0] START_CODE_RST      = 8'hF1;
  localparam logic [7:0] ESCAPE_CODE_RST     = 8'hF2;
  localparam logic [3:0] LENGTH_POSITION_RST = 4'd3;
  localparam logic [7:0] LENGTH_OVERHEAD_RST = 8'd6;

  // register indexes (word address bits)
  localparam logic [1:0] REG_START_CODE      = 2'd0;
  localparam logic [1:0] REG_ESCAPE_CODE     = 2'd1;
  localparam logic [1:0] REG_LENGTH_POSITION = 2'd2;
  localparam logic [1:0] REG_LENGTH_OVERHEAD = 2'd3;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] escape_code;
    logic [3:0] length_position;
    logic [7:0] length_overhead;
  } efr_cfg_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] frame_byte;
    logic [6:0] byte_index;
    logic       frame_started;
    logic       frame_done;
    logic [7:0] frame_length;
  } efr_result_t;

endpackage

[rtl/escaped_frame_receiver.sv]
// ----------------------------------------------------------------------------
// escaped_frame_receiver: byte-stuffing deframer with a length field
// Turns received line bytes into frame bytes, one result word per input word.
// ----------------------------------------------------------------------------
// Each input word is either a line byte (tuser = 0) or a release (tuser = 1)
// and produces exactly one result word. A word is taken every cycle unless
// the output stalls: it lands in an input register, and when the core steps
// the deframing state is updated from it while the result goes into an
// output register, so throughput is one word per cycle while the output is
// not stalled by its sink. Backpressure on the output stalls the
// input register, and the output register keeps a finished result while the
// next word is already accepted. The start code restarts a frame, the escape
// code is dropped and inverts the following byte, and a frame completes when
// the stored byte count reaches length byte plus overhead; after that line
// bytes are ignored until a release word. Registers (4-byte spacing):
// 0x0 start_code, 0x4 escape_code, 0x8 length_position, 0xC length_overhead.
// Write the registers only while no word is in flight.
module escaped_frame_receiver #(
  parameter int unsigned FRAME_CAPACITY = efr_pkg::FRAME_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_byte
  input  logic        in_tuser,   // [0] func
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] frame_byte, [14:8] byte_index,
                                  // [15] frame_started, [16] frame_done,
                                  // [24:17] frame_length, [31:25] zero
  output logic        out_tuser,  // [0] byte_valid
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  efr_pkg::efr_cfg_t    cfg;
  efr_pkg::efr_result_t core_res;

  // input register
  logic       in_v_r;
  logic       in_func_r;
  logic [7:0] in_byte_r;

  // output register
  logic                 out_v_r;
  efr_pkg::efr_result_t out_res_r;

  logic advance;

  // the core steps whenever a word is held and the output register can take its result
  assign advance   = in_v_r & (~out_v_r | out_tready);
  assign in_tready = ~in_v_r | advance;

  efr_apb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  efr_deframe_core #(
    .FRAME_CAPACITY (FRAME_CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (advance),
    .func      (in_func_r),
    .line_byte (in_byte_r),
    .cfg       (cfg),
    .res       (core_res)
  );

  // input stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_res_r.byte_valid;
  assign out_tdata  = {7'd0,
                       out_res_r.frame_length,
                       out_res_r.frame_done,
                       out_res_r.frame_started,
                       out_res_r.byte_index,
                       out_res_r.frame_byte};

  // ready only drops when both stages hold a word and the sink stalls
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (in_v_r && out_v_r && !out_tready))
    else $error("input stalled without a full pipeline");

  // a stepped word always shows up at the output next cycle
  a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("core step lost its result");

  // a stored byte leaves the frame count one past its index
  a_len_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.byte_valid) |->
      (out_res_r.frame_length[6:0] == out_res_r.byte_index + 7'd1))
    else $error("frame length does not follow byte index");

  // a start code opens an empty, incomplete frame
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_res_r.frame_started) |->
      (!out_res_r.byte_valid && !out_res_r.frame_done &&
       out_res_r.frame_length == 8'd0))
    else $error("start code result inconsistent");

endmodule

[rtl/efr_apb_regs.sv]
// ----------------------------------------------------------------------------
// efr_apb_regs: configuration register file
// APB-style write/read access to the four deframer control registers.
// ----------------------------------------------------------------------------
module efr_apb_regs (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [3:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready,
  output efr_pkg::efr_cfg_t    cfg_o
);

  efr_pkg::efr_cfg_t cfg_r;
  efr_pkg::efr_cfg_t cfg_nxt;
  logic              wr_en;
  logic [1:0]        reg_sel;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_sel    = cfg_paddr[3:2];
  assign cfg_o      = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_sel)
        efr_pkg::REG_START_CODE:      cfg_nxt.start_code      = cfg_pwdata[7:0];
        efr_pkg::REG_ESCAPE_CODE:     cfg_nxt.escape_code     = cfg_pwdata[7:0];
        efr_pkg::REG_LENGTH_POSITION: cfg_nxt.length_position = cfg_pwdata[3:0];
        efr_pkg::REG_LENGTH_OVERHEAD: cfg_nxt.length_overhead = cfg_pwdata[7:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      efr_pkg::REG_START_CODE:      cfg_prdata = {24'd0, cfg_r.start_code};
      efr_pkg::REG_ESCAPE_CODE:     cfg_prdata = {24'd0, cfg_r.escape_code};
      efr_pkg::REG_LENGTH_POSITION: cfg_prdata = {28'd0, cfg_r.length_position};
      efr_pkg::REG_LENGTH_OVERHEAD: cfg_prdata = {24'd0, cfg_r.length_overhead};
      default:                      cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code      <= efr_pkg::START_CODE_RST;
      cfg_r.escape_code     <= efr_pkg::ESCAPE_CODE_RST;
      cfg_r.length_position <= efr_pkg::LENGTH_POSITION_RST;
      cfg_r.length_overhead <= efr_pkg::LENGTH_OVERHEAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[rtl/efr_deframe_core.sv]
// ----------------------------------------------------------------------------
// efr_deframe_core: per-word deframing state and result logic
// Holds write index, previous line byte, length field and completion flag.
// ----------------------------------------------------------------------------
module efr_deframe_core #(
  parameter int unsigned FRAME_CAPACITY = efr_pkg::FRAME_CAPACITY
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  logic                  func,
  input  logic [7:0]            line_byte,
  input  efr_pkg::efr_cfg_t     cfg,
  output efr_pkg::efr_result_t  res
);

  localparam logic [7:0] CAP = 8'(FRAME_CAPACITY);

  logic [7:0] write_index_r,  write_index_nxt;
  logic [7:0] prev_byte_r,    prev_byte_nxt;
  logic [7:0] length_field_r, length_field_nxt;
  logic       complete_r,     complete_nxt;

  logic [7:0] unesc_byte;
  logic [7:0] wi_inc;
  logic [8:0] done_total;

  assign unesc_byte = (prev_byte_r == cfg.escape_code) ? ~line_byte : line_byte;
  assign wi_inc     = write_index_r + 8'd1;

  always_comb begin
    write_index_nxt  = write_index_r;
    prev_byte_nxt    = prev_byte_r;
    length_field_nxt = length_field_r;
    complete_nxt     = complete_r;
    res              = '0;
    done_total       = '0;

    if (func) begin
      complete_nxt    = 1'b0;
      write_index_nxt = efr_pkg::NO_FRAME;
    end else if (!complete_r) begin
      if (line_byte == cfg.start_code) begin
        write_index_nxt   = 8'd0;
        res.frame_started = 1'b1;
      end else if (line_byte != cfg.escape_code && write_index_r < CAP) begin
        res.byte_valid = 1'b1;
        res.frame_byte = unesc_byte;
        res.byte_index = write_index_r[6:0];
        if (write_index_r == {4'd0, cfg.length_position}) begin
          length_field_nxt = unesc_byte;
        end
        write_index_nxt = wi_inc;
        done_total      = {1'b0, length_field_nxt} + {1'b0, cfg.length_overhead};
        if ({1'b0, wi_inc} == done_total) begin
          complete_nxt = 1'b1;
        end
      end
      prev_byte_nxt = line_byte;
    end

    res.frame_done   = complete_nxt;
    res.frame_length = (write_index_nxt == efr_pkg::NO_FRAME) ? 8'd0 : write_index_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_index_r  <= efr_pkg::NO_FRAME;
      prev_byte_r    <= 8'd0;
      length_field_r <= 8'd0;
      complete_r     <= 1'b0;
    end else if (step_en) begin
      write_index_r  <= write_index_nxt;
      prev_byte_r    <= prev_byte_nxt;
      length_field_r <= length_field_nxt;
      complete_r     <= complete_nxt;
    end
  end

endmodule
